/* rtl/ball_velocity_classifier_macros.svh */
// assertion macros for the ball velocity classifier checker
// all of them sample on clk and stay quiet while rst is high
`ifndef BALL_VELOCITY_CLASSIFIER_MACROS_SVH
`define BALL_VELOCITY_CLASSIFIER_MACROS_SVH

// condition holds in the same cycle
`define BVC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition holds in the next cycle
`define BVC_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/bvc_pkg.sv */
// ----------------------------------------------------------------------------
// bvc_pkg
// Types, constants and the arctangent table shared by the classifier pipeline.
// ----------------------------------------------------------------------------
package bvc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int SQRT_STEPS        = 16;
  localparam int ATAN_LEN          = 24;

  localparam int XW  = 32;  // cordic x/y word, input scaled by 2^14
  localparam int ZW  = 30;  // angle in 1/4096 centidegree
  localparam int SQW = 32;  // sum of squares and root accumulator
  localparam int VEC_SHIFT = 14;
  localparam int ANG_FRAC  = 12;

  localparam logic signed [ZW-1:0] ANG_90   = ZW'(36864000);
  localparam logic signed [ZW-1:0] ANG_180  = ZW'(73728000);
  localparam logic signed [ZW-1:0] ANG_360  = ZW'(147456000);
  localparam logic        [ZW-1:0] ANG_HALF = ZW'(2048);

  localparam logic signed [17:0] CD_180 = 18'sd18000;
  localparam logic signed [17:0] CD_360 = 18'sd36000;
  localparam logic [15:0] SPEED_MAX = 16'd32767;

  localparam logic [24:0] ATAN_TAB [ATAN_LEN] = '{
    25'd18432000, 25'd10881045, 25'd5749245, 25'd2918407, 25'd1464867,
    25'd733147, 25'd366663, 25'd183343, 25'd91673, 25'd45837, 25'd22918,
    25'd11459, 25'd5730, 25'd2865, 25'd1432, 25'd716, 25'd358, 25'd179,
    25'd90, 25'd45, 25'd22, 25'd11, 25'd6, 25'd3
  };

  typedef enum logic [1:0] {
    CLS_STILL = 2'd0,
    CLS_OPP   = 2'd1,
    CLS_OWN   = 2'd2,
    CLS_OTHER = 2'd3
  } bvc_class_t;

  typedef enum logic [1:0] {
    REG_MIN_SPEED = 2'd0,
    REG_REACH     = 2'd1,
    REG_TOLERANCE = 2'd2
  } bvc_reg_t;

  typedef struct packed {
    logic                  valid;
    logic                  still;
    logic                  zero;
    logic                  reach;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic        [SQW-1:0] rem;
    logic        [SQW-1:0] root;
    logic signed [15:0]    opp;
    logic signed [15:0]    own;
  } bvc_item_t;

endpackage

/* rtl/bvc_in_if.sv */
// ----------------------------------------------------------------------------
// bvc_in_if
// Input channel: velocity vector, ball distance and both goal bearings.
// ----------------------------------------------------------------------------
interface bvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] velocity_x;
  logic signed [15:0] velocity_y;
  logic        [15:0] ball_distance;
  logic signed [15:0] opponent_goal_bearing;
  logic signed [15:0] own_goal_bearing;

  modport source (output valid, velocity_x, velocity_y, ball_distance,
                  opponent_goal_bearing, own_goal_bearing, input ready);
  modport sink (input valid, velocity_x, velocity_y, ball_distance,
                opponent_goal_bearing, own_goal_bearing, output ready);
endinterface

/* rtl/bvc_out_if.sv */
// ----------------------------------------------------------------------------
// bvc_out_if
// Result channel: trajectory class, heading, speed and reach flag.
// ----------------------------------------------------------------------------
interface bvc_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  trajectory_class;
  logic signed [15:0] heading;
  logic        [14:0] speed;
  logic               reach_flag;

  modport source (output valid, trajectory_class, heading, speed, reach_flag,
                  input ready);
  modport sink (input valid, trajectory_class, heading, speed, reach_flag,
                output ready);
endinterface

/* rtl/bvc_cfg_if.sv */
// ----------------------------------------------------------------------------
// bvc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ball_velocity_classifier.sv */
// ----------------------------------------------------------------------------
// ball_velocity_classifier
// Ball speed, heading, reach flag and trajectory class from a velocity vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is taken every cycle while the output is free. Each
// beat passes two entry stages, the first of which captures it at its accepting
// edge, then the chain of cordic rotations running beside the 16 root digits,
// then two stages of heading and class logic. The whole pipeline
// holds while a result waits at the output and moves on as soon as it is taken.
// Register writes are taken in any cycle; min_speed and reach_distance apply to
// beats accepted later, toward_tolerance is used at the last stage, so writes
// belong in cycles where the pipeline is empty.
module ball_velocity_classifier #(
  parameter int CORDIC_STAGES = bvc_pkg::CORDIC_STAGES_DEF
) (
  input logic       clk,
  input logic       rst,
  bvc_in_if.sink    sample,
  bvc_out_if.source result,
  bvc_cfg_if.sink   cfg
);
  import bvc_pkg::*;

  localparam int PIPE_STAGES = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  logic [14:0] min_speed;
  logic [15:0] reach_distance;
  logic [14:0] toward_tolerance;
  logic        en;
  bvc_item_t   stg [PIPE_STAGES+1];

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed        <= '0;
      reach_distance   <= '0;
      toward_tolerance <= '0;
    end else if (cfg.valid) begin
      case (bvc_reg_t'(cfg.index))
        REG_MIN_SPEED: min_speed        <= cfg.data[14:0];
        REG_REACH:     reach_distance   <= cfg.data;
        REG_TOLERANCE: toward_tolerance <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  bvc_front u_front (
    .clk                   (clk),
    .rst                   (rst),
    .en                    (en),
    .valid                 (sample.valid),
    .velocity_x            (sample.velocity_x),
    .velocity_y            (sample.velocity_y),
    .ball_distance         (sample.ball_distance),
    .opponent_goal_bearing (sample.opponent_goal_bearing),
    .own_goal_bearing      (sample.own_goal_bearing),
    .min_speed             (min_speed),
    .reach_distance        (reach_distance),
    .item                  (stg[0])
  );

  for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_stage
    bvc_stage #(
      .IDX (i),
      .ROT (i < CORDIC_STAGES)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (stg[i]),
      .q   (stg[i+1])
    );
  end

  bvc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .d                (stg[PIPE_STAGES]),
    .toward_tolerance (toward_tolerance),
    .valid            (result.valid),
    .trajectory_class (result.trajectory_class),
    .heading          (result.heading),
    .speed            (result.speed),
    .reach_flag       (result.reach_flag)
  );

endmodule

/* rtl/bvc_front.sv */
// ----------------------------------------------------------------------------
// bvc_front
// Two entry stages: squares and half-plane fold, then sum and still test.
// ----------------------------------------------------------------------------
module bvc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid,
  input  logic signed [15:0]  velocity_x,
  input  logic signed [15:0]  velocity_y,
  input  logic        [15:0]  ball_distance,
  input  logic signed [15:0]  opponent_goal_bearing,
  input  logic signed [15:0]  own_goal_bearing,
  input  logic        [14:0]  min_speed,
  input  logic        [15:0]  reach_distance,
  output bvc_pkg::bvc_item_t  item
);
  import bvc_pkg::*;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 reach;
    logic        [30:0]   sqx;
    logic        [30:0]   sqy;
    logic        [29:0]   msq;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   opp;
    logic signed [15:0]   own;
  } bvc_sq_t;

  bvc_sq_t   sq;
  bvc_sq_t   sq_next;
  bvc_item_t item_next;
  logic signed [31:0]   px;
  logic signed [31:0]   py;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic        [SQW-1:0] sum;

  always_comb begin
    px = velocity_x * velocity_x;
    py = velocity_y * velocity_y;
    xs = {{(XW-16-VEC_SHIFT){velocity_x[15]}}, velocity_x, {VEC_SHIFT{1'b0}}};
    ys = {{(XW-16-VEC_SHIFT){velocity_y[15]}}, velocity_y, {VEC_SHIFT{1'b0}}};
    sq_next.valid = valid;
    sq_next.zero  = (velocity_x == 16'sd0) && (velocity_y == 16'sd0);
    sq_next.reach = (reach_distance != 16'd0) && (ball_distance <= reach_distance);
    sq_next.sqx   = px[30:0];
    sq_next.sqy   = py[30:0];
    sq_next.msq   = 30'(min_speed * min_speed);
    sq_next.opp   = opponent_goal_bearing;
    sq_next.own   = own_goal_bearing;
    // fold left half plane onto the right, start at +-180 degrees
    if (velocity_x < 16'sd0) begin
      sq_next.x = -xs;
      sq_next.y = -ys;
      sq_next.z = (velocity_y >= 16'sd0) ? ANG_180 : -ANG_180;
    end else begin
      sq_next.x = xs;
      sq_next.y = ys;
      sq_next.z = '0;
    end
  end

  always_comb begin
    sum = SQW'(sq.sqx) + SQW'(sq.sqy);
    item_next.valid = sq.valid;
    item_next.still = sum < SQW'(sq.msq);
    item_next.zero  = sq.zero;
    item_next.reach = sq.reach;
    item_next.x     = sq.x;
    item_next.y     = sq.y;
    item_next.z     = sq.z;
    item_next.rem   = sum;
    item_next.root  = '0;
    item_next.opp   = sq.opp;
    item_next.own   = sq.own;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq.valid   <= 1'b0;
      item.valid <= 1'b0;
    end else if (en) begin
      sq   <= sq_next;
      item <= item_next;
    end
  end

endmodule

/* rtl/bvc_stage.sv */
// ----------------------------------------------------------------------------
// bvc_stage
// One step: cordic vectoring rotation if ROT, root digit if IDX < SQRT_STEPS.
// ----------------------------------------------------------------------------
module bvc_stage #(
  parameter int IDX = 0,
  parameter bit ROT = 1'b1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bvc_pkg::bvc_item_t d,
  output bvc_pkg::bvc_item_t q
);
  import bvc_pkg::*;

  localparam bit SQ  = IDX < SQRT_STEPS;
  localparam int SHB = SQ ? 30 - 2 * IDX : 0;
  localparam logic [SQW:0] BITV = (SQW + 1)'(1) << SHB;
  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[IDX]);

  bvc_item_t nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic [SQW:0] trial;

  always_comb begin
    nxt   = d;
    xs    = d.x >>> IDX;
    ys    = d.y >>> IDX;
    trial = {1'b0, d.root} + BITV;
    if (ROT) begin
      if (d.y > 0) begin
        nxt.x = d.x + ys;
        nxt.y = d.y - xs;
        nxt.z = d.z + ATAN;
      end else begin
        nxt.x = d.x - ys;
        nxt.y = d.y + xs;
        nxt.z = d.z - ATAN;
      end
    end
    if (SQ) begin
      if ({1'b0, d.rem} >= trial) begin
        nxt.rem  = d.rem - trial[SQW-1:0];
        nxt.root = (d.root >> 1) + BITV[SQW-1:0];
      end else begin
        nxt.root = d.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

/* rtl/bvc_back.sv */
// ----------------------------------------------------------------------------
// bvc_back
// Heading wrap and rounding, then goal comparison into the output register.
// ----------------------------------------------------------------------------
module bvc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bvc_pkg::bvc_item_t d,
  input  logic [14:0]        toward_tolerance,
  output logic               valid,
  output logic [1:0]         trajectory_class,
  output logic signed [15:0] heading,
  output logic [14:0]        speed,
  output logic               reach_flag
);
  import bvc_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               still;
    logic               reach;
    logic signed [15:0] hd;
    logic        [14:0] spd;
    logic signed [15:0] opp;
    logic signed [15:0] own;
  } bvc_head_t;

  bvc_head_t hr;
  bvc_head_t hr_next;
  logic signed [ZW-1:0] h;
  logic        [ZW-1:0] mag;
  logic        [ZW-1:0] rnd;
  logic        [15:0]   dopp;
  logic        [15:0]   down;
  bvc_class_t           cls;

  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [17:0] df;
    df = 18'(a) - 18'(b);
    if (df > CD_180) begin
      df = df - CD_360;
    end else if (df <= -CD_180) begin
      df = df + CD_360;
    end
    if (df < 0) begin
      df = -df;
    end
    return df[15:0];
  endfunction

  always_comb begin
    // zero vector takes atan2 as zero
    h = d.zero ? ANG_90 : ANG_90 - d.z;
    if (h > ANG_180) begin
      h = h - ANG_360;
    end else if (h <= -ANG_180) begin
      h = h + ANG_360;
    end
    mag = (h < 0) ? ZW'(-h) : ZW'(h);
    rnd = (mag + ANG_HALF) >> ANG_FRAC;
    hr_next.valid = d.valid;
    hr_next.still = d.still;
    hr_next.reach = d.reach;
    hr_next.hd    = (h < 0) ? -16'(rnd) : 16'(rnd);
    hr_next.spd   = (d.root[15:0] > SPEED_MAX) ? SPEED_MAX[14:0] : d.root[14:0];
    hr_next.opp   = d.opp;
    hr_next.own   = d.own;
  end

  always_comb begin
    dopp = abs_diff(hr.hd, hr.opp);
    down = abs_diff(hr.hd, hr.own);
    if (hr.still) begin
      cls = CLS_STILL;
    end else if (dopp <= 16'(toward_tolerance) && dopp <= down) begin
      cls = CLS_OPP;
    end else if (down <= 16'(toward_tolerance)) begin
      cls = CLS_OWN;
    end else begin
      cls = CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hr.valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      hr               <= hr_next;
      valid            <= hr.valid;
      trajectory_class <= cls;
      heading          <= hr.still ? 16'sd0 : hr.hd;
      speed            <= hr.spd;
      reach_flag       <= hr.reach;
    end
  end

endmodule

/* rtl/bvc_checker.sv */
// ----------------------------------------------------------------------------
// bvc_checker
// Port-level checks on the classifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "ball_velocity_classifier_macros.svh"

module bvc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         cls,
  input logic signed [15:0] heading
);
  import bvc_pkg::*;

  // a taken result always frees the input side
  `BVC_ASSERT_IMP(a_ready_follows, out_ready, in_ready, "input stalled while output taken")
  // still beats report no heading
  `BVC_ASSERT_IMP(a_still_heading, out_valid && cls == CLS_STILL, heading == 16'sd0, "still with heading")
  `BVC_ASSERT_IMP(a_heading_range, out_valid, heading >= -16'sd18000 && heading <= 16'sd18000, "heading out of range")
  `BVC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(heading) && $stable(cls), "stalled beat changed")

endmodule

bind ball_velocity_classifier bvc_checker u_bvc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .cls       (result.trajectory_class),
  .heading   (result.heading)
);
